// File: rtl/sha256_pkg.sv
// Package for the SHA-256 stream hasher: payload types, round constants,
// initial hash values and the rotate-right function rotr. No dependencies.
`default_nettype none
package sha256_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       finish;
    logic       restart;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  // Request from the sequencer to the compression core. The core holds its
  // first 16 rounds until w_valid shows a message word.
  typedef struct packed {
    logic start;
    logic w_valid;
  } core_ctrl_t;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam int unsigned LEN_POS = 56;

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage
`default_nettype wire

// File: rtl/sha256_if.sv
// Valid/ready channel interface carrying one payload word.
// Depends on nothing; the payload type is a parameter.
`default_nettype none
interface sha256_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: rtl/sha256_core.sv
// SHA-256 compression core: one round per cycle, the first 16 rounds only while
// w_valid shows a message word; message schedule kept in a 16-word sliding window. Depends on sha256_pkg.
`default_nettype none
module sha256_core
  import sha256_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire core_ctrl_t        ctrl,
  input  wire logic [31:0]       w_in,     // message word for rounds 0..15
  input  wire logic [255:0]      h_in,
  output logic                   want_word,
  output logic                   done,
  output logic [255:0]           h_out
);
  logic        busy;
  logic        step;
  logic [6:0]  rnd;
  logic [31:0] win [16];
  logic [31:0] va, vb, vc, vd, ve, vf, vg, vh;
  logic [31:0] wt, s0, s1, t1, t2, wnew;

  assign want_word = busy && (rnd < 7'd16);
  // The first 16 rounds wait for their message word.
  assign step      = busy && ((rnd >= 7'd16) || ctrl.w_valid);

  always_comb begin
    s0   = rotr(win[1], 7) ^ rotr(win[1], 18) ^ (win[1] >> 3);
    s1   = rotr(win[14], 17) ^ rotr(win[14], 19) ^ (win[14] >> 10);
    wnew = win[0] + s0 + win[9] + s1;
    wt   = (rnd < 7'd16) ? w_in : wnew;
    t1 = vh + (rotr(ve, 6) ^ rotr(ve, 11) ^ rotr(ve, 25)) + ((ve & vf) ^ (~ve & vg))
         + ROUND_K[rnd[5:0]] + wt;
    t2 = (rotr(va, 2) ^ rotr(va, 13) ^ rotr(va, 22)) + ((va & vb) ^ (va & vc) ^ (vb & vc));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rnd  <= '0;
      done <= 1'b0;
    end else begin
      done <= step && (rnd == 7'd63);
      if (ctrl.start && !busy) begin
        busy <= 1'b1;
        rnd  <= '0;
      end else if (step) begin
        if (rnd == 7'd63) begin
          busy <= 1'b0;
        end
        rnd <= rnd + 7'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start && !busy) begin
      {va, vb, vc, vd, ve, vf, vg, vh} <= h_in;
    end else if (step) begin
      for (int i = 0; i < 15; i++) win[i] <= win[i + 1];
      win[15] <= wt;
      vh <= vg; vg <= vf; vf <= ve; ve <= vd + t1;
      vd <= vc; vc <= vb; vb <= va; va <= t1 + t2;
    end
  end

  always_comb begin
    h_out[255:224] = h_in[255:224] + va;
    h_out[223:192] = h_in[223:192] + vb;
    h_out[191:160] = h_in[191:160] + vc;
    h_out[159:128] = h_in[159:128] + vd;
    h_out[127:96]  = h_in[127:96]  + ve;
    h_out[95:64]   = h_in[95:64]   + vf;
    h_out[63:32]   = h_in[63:32]   + vg;
    h_out[31:0]    = h_in[31:0]    + vh;
  end
endmodule
`default_nettype wire

// File: rtl/sha256_stream_hasher_top.sv
// Top level of the byte-stream SHA-256 hasher: block memory, sequencer and
// output register. Depends on sha256_pkg, sha256_if and sha256_core.
//
// Usage: in_ch carries one word per item (data_byte, has_byte, finish,
// restart); out_ch carries digest words 0..7, last_word marking word 7.
// in_ch.ready is high only while the block is idle. A word that neither
// completes a block, finishes nor restarts leaves the block idle; a restart
// alone passes through the fold state first.
// Each block is compressed from a 64x8 memory read one byte per cycle while
// no message word waits for the core, so each of the 16 message words costs
// a priming read, four byte reads and a hand-over to the core, which waits
// for it; 48 more rounds then follow at one per cycle. A word that completes
// a block holds the input until that block is compressed and folded. A finish
// compresses one or two padded blocks, after the block that the finishing
// word completes, if any; the digest words follow one per cycle while the
// receiver is ready. A stalled receiver holds the word in the output
// register; after the last word is taken the block passes through the fold
// state before the input is ready again. Reset loads the initial hash values
// and clears the counts; the block memory is not cleared. Restart applies
// after the item.
`default_nettype none
module sha256_stream_hasher_top
  import sha256_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  sha256_if.sink   in_ch,
  sha256_if.source out_ch
);
  localparam logic [3:0] S_IDLE = 4'd0, S_RD = 4'd1, S_RUN = 4'd2, S_FOLD = 4'd3,
                         S_PAD = 4'd4, S_OUT = 4'd5;

  logic [3:0]   state;
  logic [7:0]   mem [64];
  logic [7:0]   rdata;
  logic [5:0]   raddr;
  logic [5:0]   fill;
  logic [63:0]  total;
  logic [255:0] chain, work;
  in_item_t     held;
  logic         pad_mode;   // compressing a padded block (finish path)
  logic         second;     // second padded block pending
  logic [5:0]   pad_f;      // fill count at finish
  logic         pad_first;  // this padded block holds the 0x80 marker
  logic         core_busy;
  logic [1:0]   bcnt;
  logic [23:0]  wacc;
  logic [31:0]  wbuf;
  logic         wbuf_ok;
  logic [3:0]   wword;
  logic [2:0]   oidx;
  core_ctrl_t   cc;
  logic         want_word, core_done;
  logic [255:0] h_out;
  logic [63:0]  bits;

  assign bits = {total[60:0], 3'b000};
  assign in_ch.ready = (state == S_IDLE);

  // Byte of the current (possibly padded) block at address a given memory data.
  function automatic logic [7:0] pad_byte(input logic [5:0] a, input logic [7:0] d,
                                          input logic first, input logic [5:0] f,
                                          input logic [63:0] b, input logic has_len);
    logic [7:0] r;
    r = 8'h00;
    if (first && a < f) r = d;
    else if (first && a == f) r = PAD_BYTE;
    if (has_len && a >= 6'(LEN_POS)) r = b[8'(63 - 8 * (a - 6'(LEN_POS))) -: 8];
    return r;
  endfunction

  logic [7:0] cur_byte;
  logic       has_len;
  assign has_len  = !(pad_first && pad_f >= 6'(LEN_POS));
  assign cur_byte = pad_mode ? pad_byte(raddr - 6'd1, rdata, pad_first, pad_f, bits, has_len)
                             : rdata;

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (state == S_IDLE && in_ch.valid && in_ch.payload.has_byte)
      mem[fill] <= in_ch.payload.data_byte;
  end

  assign cc = '{start: (state == S_RD) && wbuf_ok && !core_busy,
                w_valid: (state == S_RD) && wbuf_ok};

  sha256_core u_core (
    .clk, .rst, .ctrl(cc), .w_in(wbuf), .h_in(pad_mode ? work : chain),
    .want_word, .done(core_done), .h_out
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      total     <= '0;
      chain     <= {INIT_H[0], INIT_H[1], INIT_H[2], INIT_H[3],
                    INIT_H[4], INIT_H[5], INIT_H[6], INIT_H[7]};
      out_ch.valid <= 1'b0;
      core_busy <= 1'b0;
      wbuf_ok   <= 1'b0;
      pad_mode  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            held <= in_ch.payload;
            pad_f <= in_ch.payload.has_byte ? fill + 6'd1 : fill;
            if (in_ch.payload.has_byte) begin
              fill  <= fill + 6'd1;
              total <= total + 64'd1;
            end
            raddr <= '0; bcnt <= '0; wword <= '0; wbuf_ok <= 1'b0;
            if (in_ch.payload.has_byte && fill == 6'd63) begin
              pad_mode <= 1'b0; state <= S_RD;
            end else if (in_ch.payload.finish) begin
              state <= S_PAD;
            end else if (in_ch.payload.restart) begin
              state <= S_FOLD;
            end
          end
        end
        S_PAD: begin
          pad_mode <= 1'b1; pad_first <= 1'b1; second <= 1'b0;
          work <= chain; raddr <= '0; bcnt <= '0; wword <= '0; wbuf_ok <= 1'b0;
          state <= S_RD;
        end
        S_RD: begin
          // Read four bytes per message word; the core holds its first 16
          // rounds until the word is handed over.
          if (cc.start) core_busy <= 1'b1;
          if (!wbuf_ok) begin
            if (raddr != {wword[3:0], 2'b00} || bcnt != 2'd0) begin
              wacc <= {wacc[15:0], cur_byte};
              bcnt <= bcnt + 2'd1;
              if (bcnt == 2'd3) begin
                wbuf <= {wacc, cur_byte};
                wbuf_ok <= 1'b1;
              end else begin
                raddr <= raddr + 6'd1;
              end
            end else begin
              raddr <= raddr + 6'd1;
            end
          end else if (want_word) begin
            wbuf_ok <= 1'b0;
            wword <= wword + 4'd1;
            if (wword == 4'd15) state <= S_RUN;
          end
        end
        S_RUN: begin
          if (core_done) begin
            core_busy <= 1'b0;
            if (pad_mode) begin
              work <= h_out;
              if (pad_first && pad_f >= 6'(LEN_POS) && !second) begin
                second <= 1'b1; pad_first <= 1'b0;
                raddr <= '0; bcnt <= '0; wword <= '0; wbuf_ok <= 1'b0;
                state <= S_RD;
              end else begin
                oidx <= '0; state <= S_OUT;
              end
            end else begin
              chain <= h_out;
              state <= held.finish ? S_PAD : S_FOLD;
            end
          end
        end
        S_OUT: begin
          if (!out_ch.valid || out_ch.ready) begin
            if (out_ch.valid && out_ch.payload.last_word) begin
              out_ch.valid <= 1'b0;
              state <= S_FOLD;
            end else begin
              out_ch.valid <= 1'b1;
              out_ch.payload.digest_word <= work[8'(255 - 32 * oidx) -: 32];
              out_ch.payload.word_index  <= oidx;
              out_ch.payload.last_word   <= (oidx == 3'd7);
              oidx <= oidx + 3'd1;
            end
          end
        end
        S_FOLD: begin
          pad_mode <= 1'b0;
          if (held.restart) begin
            fill  <= '0;
            total <= '0;
            chain <= {INIT_H[0], INIT_H[1], INIT_H[2], INIT_H[3],
                      INIT_H[4], INIT_H[5], INIT_H[6], INIT_H[7]};
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: rtl/sha256_checker.sv
// Port-level checker for the SHA-256 stream hasher, bound to the top level.
// Depends on sha256_pkg and sha256_stream_hasher_top.
`default_nettype none
module sha256_checker
  import sha256_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_payload
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_payload)) else $error("stall");
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_payload.last_word == (out_payload.word_index == 3'd7)))
    else $error("last");
  a_seq: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_payload.last_word |=> out_valid ||
    !in_ready) else $error("gap");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("ready during output");
endmodule

bind sha256_stream_hasher_top sha256_checker u_chk (
  .clk, .rst, .in_ready(in_ch.ready), .out_valid(out_ch.valid),
  .out_ready(out_ch.ready), .out_payload(out_ch.payload)
);
`default_nettype wire
